// File: hw/rtl/rrb_pkg.sv
// Shared types and constants for the receive reorder buffer.
// Used by the controller, the datapath, the modulo unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rrb_pkg;

	localparam int SEQ_W       = 31;
	localparam int SIZE_W      = 11;
	localparam int TAG_W       = 16;
	localparam int KIND_W      = 2;
	localparam int HIGH_W      = 32;
	localparam int CNT_W       = 6;
	localparam int WS_W        = 6;
	localparam int WS_RESET    = 32;
	localparam int HDR_BYTES   = 7;
	localparam int MAX_OUT     = 32;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + SEQ_W + TAG_W + SIZE_W + HIGH_W + CNT_W);

	localparam int MOD_STEP_BITS = 4;
	localparam int MOD_STEPS     = 8;
	localparam int MOD_NUM_W     = MOD_STEP_BITS * MOD_STEPS;
	localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_PACKET = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MOD,
		ST_INS,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] size;
		logic [SEQ_W-1:0]  seq;
	} slot_t;

	typedef struct packed {
		logic load_in;
		logic start_mod;
		logic ins_push;
		logic load_idx;
		logic rd_slot;
		logic walk_hit;
		logic walk_end;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic beyond;
		logic mod_done;
		logic out_free;
		logic hit;
		logic cnt_full;
		logic pend_vld;
	} sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/receiver_reorder_buffer_top.sv
// Top level of the receive reorder buffer: joins the controller and the datapath.
// Depends on rrb_pkg, rrb_ctrl, rrb_dp and rrb_mod.
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window receive reorder buffer. An insert word stores a packet in slot seq mod window
// and returns one status word. A flush word advances the expected sequence number by one and
// then returns the stored packets in order, up to 32, until a sequence number is missing, or
// one word saying nothing was delivered. One word is handled at a time. An insert waits for
// the remainder unit, which works four bits of the sequence number per cycle; an insert
// beyond the window skips it. A flush also runs the remainder unit and then, for each slot
// it visits, does a registered read of the slot memory and a check. Both wait while the
// output register waits for the receiver. A result waiting in the output register does not
// stop the next word from being taken. The user must write the window size only while the
// block is idle; the block itself does not enforce it.

module receiver_reorder_buffer_top #(
	parameter int WINDOW_DEPTH = 32,
	parameter int MAX_PACKET   = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [rrb_pkg::WS_W-1:0]           cfg_wr_data,   // slots in use
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [rrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // seq_num, packet_size, payload_tag
	input  wire logic                               s_axis_tuser,  // command
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [rrb_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // accepted, out_seq, out_tag,
	                                                               // payload_len, highest_seen,
	                                                               // flushed_count
	output logic [rrb_pkg::KIND_W-1:0]              m_axis_tuser,  // kind
	output logic                                    m_axis_tlast
);

	rrb_pkg::cmd_t cmd;
	rrb_pkg::sts_t sts;

	rrb_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	rrb_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.MAX_PACKET   (MAX_PACKET)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_data       (s_axis_tdata),
		.in_cmd        (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: hw/rtl/rrb_mod.sv
// Iterative remainder unit: sequence number modulo the window, four bits per cycle.
// Depends on rrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrb_mod #(
	parameter int DW = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rrb_pkg::SEQ_W-1:0] dividend,
	input  wire logic [DW-1:0]             divisor,
	output logic                           done,
	output logic [DW-1:0]                  rem
);

	logic                              busy_q;
	logic                              done_q;
	logic [rrb_pkg::MOD_CNT_W-1:0]     step_q;
	logic [rrb_pkg::MOD_NUM_W-1:0]     num_q;
	logic [DW-1:0]                     div_q;
	logic [DW-1:0]                     rem_q;
	logic [DW-1:0]                     rem_nxt;

	always_comb begin
		logic [DW:0] t;
		rem_nxt = rem_q;
		for (int i = 0; i < rrb_pkg::MOD_STEP_BITS; i++) begin
			t = {rem_nxt, num_q[rrb_pkg::MOD_NUM_W-1-i]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_nxt = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == rrb_pkg::MOD_CNT_W'(rrb_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= rrb_pkg::MOD_NUM_W'(dividend);
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << rrb_pkg::MOD_STEP_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/rrb_dp.sv
// Datapath of the reorder buffer: item registers, slot memory, window state and output word.
// Depends on rrb_pkg and rrb_mod.
`timescale 1ns / 1ps
`default_nettype none

module rrb_dp #(
	parameter int WINDOW_DEPTH = 32,
	parameter int MAX_PACKET   = 2048
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [rrb_pkg::WS_W-1:0]        cfg_wr_data,
	input  wire logic [rrb_pkg::IN_TDATA_W-1:0]  in_data,
	input  wire logic                            in_cmd,
	input  wire rrb_pkg::cmd_t                   cmd,
	output rrb_pkg::sts_t                        sts,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [rrb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [rrb_pkg::KIND_W-1:0]           m_axis_tuser,
	output logic                                 m_axis_tlast
);

	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WW = $clog2(WINDOW_DEPTH + 1);
	localparam int SizeMaxInt = (MAX_PACKET > 2047) ? 2047 : MAX_PACKET;
	localparam logic [rrb_pkg::SIZE_W-1:0] SizeMax = rrb_pkg::SIZE_W'(SizeMaxInt);
	localparam logic [6:0] Depth7 = 7'(WINDOW_DEPTH);

	logic                              in_cmd_q;
	logic [rrb_pkg::SEQ_W-1:0]         in_seq_q;
	logic [rrb_pkg::SIZE_W-1:0]        in_size_q;
	logic [rrb_pkg::TAG_W-1:0]         in_tag_q;

	logic [rrb_pkg::WS_W-1:0]          win_q;
	logic [rrb_pkg::SEQ_W-1:0]         expected_q;
	logic signed [rrb_pkg::HIGH_W-1:0] highest_q;
	logic [WINDOW_DEPTH-1:0]           slot_vld_q;
	logic [IW-1:0]                     idx_q;
	logic [rrb_pkg::CNT_W-1:0]         cnt_q;

	rrb_pkg::slot_t                    slot_mem [WINDOW_DEPTH];
	rrb_pkg::slot_t                    rd_slot_s1;
	logic                              rd_vld_s1;

	logic                              pend_vld_q;
	logic [rrb_pkg::SEQ_W-1:0]         pend_seq_q;
	logic [rrb_pkg::TAG_W-1:0]         pend_tag_q;
	logic [rrb_pkg::SIZE_W-1:0]        pend_len_q;
	logic [rrb_pkg::CNT_W-1:0]         pend_cnt_q;

	logic                              out_valid_q;
	rrb_pkg::kind_t                    out_kind_q;
	logic                              out_acc_q;
	logic [rrb_pkg::SEQ_W-1:0]         out_seq_q;
	logic [rrb_pkg::TAG_W-1:0]         out_tag_q;
	logic [rrb_pkg::SIZE_W-1:0]        out_len_q;
	logic signed [rrb_pkg::HIGH_W-1:0] out_high_q;
	logic [rrb_pkg::CNT_W-1:0]         out_cnt_q;
	logic                              out_last_q;

	logic [6:0]                        ws7;
	logic [6:0]                        eff7;
	logic [WW-1:0]                     eff_win;
	logic [rrb_pkg::HIGH_W-1:0]        bound;
	logic                              beyond;
	logic [rrb_pkg::SEQ_W-1:0]         exp_inc;
	logic [rrb_pkg::SEQ_W-1:0]         mod_dividend;
	logic                              mod_done;
	logic [WW-1:0]                     mod_rem;
	logic [IW-1:0]                     ins_idx;
	logic [WW-1:0]                     idx_inc;
	logic [IW-1:0]                     idx_nxt;
	logic [rrb_pkg::SIZE_W-1:0]        size_clamped;
	logic [rrb_pkg::SIZE_W-1:0]        rd_len;
	logic                              out_free;
	logic                              ins_write;
	logic                              hit;

	assign ws7     = 7'(win_q);
	assign eff7    = (ws7 == 7'd0) ? 7'd1 : ((ws7 > Depth7) ? Depth7 : ws7);
	assign eff_win = eff7[WW-1:0];

	assign bound  = {1'b0, expected_q} + rrb_pkg::HIGH_W'(eff_win);
	assign beyond = {1'b0, in_seq_q} > bound;

	assign exp_inc      = expected_q + 1'b1;
	assign mod_dividend = (in_cmd_q == rrb_pkg::CMD_FLUSH) ? exp_inc : in_seq_q;

	rrb_mod #(
		.DW(WW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_mod),
		.dividend (mod_dividend),
		.divisor  (eff_win),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign ins_idx = mod_rem[IW-1:0];
	assign idx_inc = WW'(idx_q) + 1'b1;
	assign idx_nxt = (idx_inc == eff_win) ? '0 : idx_inc[IW-1:0];

	assign size_clamped = (in_size_q > SizeMax) ? SizeMax : in_size_q;
	assign rd_len = (rd_slot_s1.size > rrb_pkg::SIZE_W'(rrb_pkg::HDR_BYTES)) ?
		rd_slot_s1.size - rrb_pkg::SIZE_W'(rrb_pkg::HDR_BYTES) : '0;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign ins_write = cmd.ins_push && !beyond;
	assign hit       = rd_vld_s1 && (rd_slot_s1.seq == expected_q);

	assign sts.is_flush = (in_cmd_q == rrb_pkg::CMD_FLUSH);
	assign sts.beyond   = beyond;
	assign sts.mod_done = mod_done;
	assign sts.out_free = out_free;
	assign sts.hit      = hit;
	assign sts.cnt_full = (cnt_q == rrb_pkg::CNT_W'(rrb_pkg::MAX_OUT));
	assign sts.pend_vld = pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= rrb_pkg::WS_W'(rrb_pkg::WS_RESET);
			expected_q  <= '0;
			highest_q   <= '1;
			slot_vld_q  <= '0;
			cnt_q       <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_q <= cfg_wr_data;
			end
			if (cmd.start_mod && (in_cmd_q == rrb_pkg::CMD_FLUSH)) begin
				expected_q <= exp_inc;
			end
			if (ins_write) begin
				slot_vld_q[ins_idx] <= 1'b1;
				if ($signed({1'b0, in_seq_q}) > highest_q) begin
					highest_q <= $signed({1'b0, in_seq_q});
				end
			end
			if (cmd.load_idx) begin
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end
			if (cmd.walk_hit) begin
				slot_vld_q[idx_q] <= 1'b0;
				expected_q        <= exp_inc;
				cnt_q             <= cnt_q + 1'b1;
				pend_vld_q        <= 1'b1;
			end
			if (cmd.walk_end) begin
				pend_vld_q <= 1'b0;
			end
			if (cmd.ins_push || cmd.walk_end || (cmd.walk_hit && pend_vld_q)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_cmd_q  <= in_cmd;
			in_seq_q  <= in_data[rrb_pkg::SEQ_W-1:0];
			in_size_q <= in_data[rrb_pkg::SEQ_W +: rrb_pkg::SIZE_W];
			in_tag_q  <= in_data[rrb_pkg::SEQ_W + rrb_pkg::SIZE_W +: rrb_pkg::TAG_W];
		end
		if (ins_write) begin
			slot_mem[ins_idx] <= '{tag: in_tag_q, size: size_clamped, seq: in_seq_q};
		end
		if (cmd.rd_slot) begin
			rd_slot_s1 <= slot_mem[idx_q];
			rd_vld_s1  <= slot_vld_q[idx_q];
		end
		if (cmd.load_idx) begin
			idx_q <= ins_idx;
		end
		if (cmd.walk_hit) begin
			idx_q      <= idx_nxt;
			pend_seq_q <= expected_q;
			pend_tag_q <= rd_slot_s1.tag;
			pend_len_q <= rd_len;
			pend_cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.ins_push) begin
			out_kind_q <= rrb_pkg::KIND_INSERT;
			out_acc_q  <= !beyond;
			out_seq_q  <= '0;
			out_tag_q  <= '0;
			out_len_q  <= '0;
			out_cnt_q  <= '0;
			out_last_q <= 1'b1;
			if (ins_write && ($signed({1'b0, in_seq_q}) > highest_q)) begin
				out_high_q <= $signed({1'b0, in_seq_q});
			end else begin
				out_high_q <= highest_q;
			end
		end else if (cmd.walk_end && !pend_vld_q) begin
			out_kind_q <= rrb_pkg::KIND_EMPTY;
			out_acc_q  <= 1'b0;
			out_seq_q  <= '0;
			out_tag_q  <= '0;
			out_len_q  <= '0;
			out_cnt_q  <= '0;
			out_high_q <= highest_q;
			out_last_q <= 1'b1;
		end else if (cmd.walk_end || (cmd.walk_hit && pend_vld_q)) begin
			out_kind_q <= rrb_pkg::KIND_PACKET;
			out_acc_q  <= 1'b0;
			out_seq_q  <= pend_seq_q;
			out_tag_q  <= pend_tag_q;
			out_len_q  <= pend_len_q;
			out_cnt_q  <= pend_cnt_q;
			out_high_q <= highest_q;
			out_last_q <= cmd.walk_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{rrb_pkg::OUT_PAD_W{1'b0}}, out_cnt_q, out_high_q, out_len_q,
		out_tag_q, out_seq_q, out_acc_q};

endmodule

`default_nettype wire

// File: hw/rtl/rrb_ctrl.sv
// Controller state machine of the reorder buffer: sequences insert and flush items.
// Depends on rrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire rrb_pkg::sts_t sts,
	output rrb_pkg::cmd_t      cmd
);

	rrb_pkg::state_t state_q;
	rrb_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			rrb_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = rrb_pkg::ST_START;
				end
			end
			rrb_pkg::ST_START: begin
				if (!sts.is_flush && sts.beyond) begin
					state_nxt = rrb_pkg::ST_INS;
				end else begin
					cmd.start_mod = 1'b1;
					state_nxt     = rrb_pkg::ST_MOD;
				end
			end
			rrb_pkg::ST_MOD: begin
				if (sts.mod_done) begin
					if (sts.is_flush) begin
						cmd.load_idx = 1'b1;
						state_nxt    = rrb_pkg::ST_READ;
					end else begin
						state_nxt = rrb_pkg::ST_INS;
					end
				end
			end
			rrb_pkg::ST_INS: begin
				if (sts.out_free) begin
					cmd.ins_push = 1'b1;
					state_nxt    = rrb_pkg::ST_IDLE;
				end
			end
			rrb_pkg::ST_READ: begin
				cmd.rd_slot = 1'b1;
				state_nxt   = rrb_pkg::ST_CHECK;
			end
			rrb_pkg::ST_CHECK: begin
				if (sts.hit && !sts.cnt_full) begin
					if (!sts.pend_vld || sts.out_free) begin
						cmd.walk_hit = 1'b1;
						state_nxt    = rrb_pkg::ST_READ;
					end
				end else if (sts.out_free) begin
					cmd.walk_end = 1'b1;
					state_nxt    = rrb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rrb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
